// ===== hdl/mwtg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mwtg_pkg
// Shared types, register codes and constants of the multi-waveform tone
// generator.
// ----------------------------------------------------------------------------
package mwtg_pkg;

    localparam int DEF_SAMPLE_BITS      = 16;
    localparam int DEF_SINE_TABLE_DEPTH = 256;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_WAVEFORM       = 3'd0,
        REG_PERIOD_WHOLE   = 3'd1,
        REG_PERIOD_FRAC    = 3'd2,
        REG_PHASE_STEP     = 3'd3,
        REG_AMPLITUDE      = 3'd4,
        REG_CHANNEL_ENABLE = 3'd5
    } t_cfg_addr;

    typedef enum logic [2:0] {
        TONE_SINE     = 3'd0,
        TONE_SQUARE   = 3'd1,
        TONE_SAW      = 3'd2,
        TONE_TRIANGLE = 3'd3,
        TONE_NOISE    = 3'd4
    } t_wave;

    // scaling applied after the amplitude multiply
    typedef enum logic [1:0] {
        SCALE_Q32     = 2'd0,
        SCALE_DIV_15  = 2'd1,
        SCALE_DIV_16  = 2'd2
    } t_scale;

    localparam logic [15:0] RST_PERIOD_WHOLE = 16'd441;
    localparam logic [15:0] RST_PERIOD_FRAC  = 16'd0;
    localparam logic [31:0] RST_PHASE_STEP   = 32'd9739155;

    localparam logic [15:0] NOISE_SEED = 16'hACE1;
    localparam logic [15:0] NOISE_TAPS = 16'hB400;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint          ONE_Q30     = 64'sd1073741824;

    // next Taylor term of the sine series before the factorial step, Q30
    function automatic longint unsigned taylor_next(input longint unsigned term,
                                                    input longint unsigned x);
        longint unsigned t;
        t = (term * x) >> 30;
        t = (t * x) >> 30;
        return t;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/multi_waveform_tone_generator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// multi_waveform_tone_generator
// Stereo tone source: sine, square, sawtooth, triangle or noise per frame.
// ----------------------------------------------------------------------------
// Each input transfer yields one stereo frame. The block accepts one transfer
// per clock and delivers one frame per clock unless m_axis_tready stalls it;
// a frame passes the operand stage, amplitude multiply, and scale and output
// register. The period position, ramp phase, sine phase and, in noise mode,
// the noise register advance at input acceptance, so the rate is one frame
// per cycle without stall. The sine uses a constant quarter-wave table of
// SINE_TABLE_DEPTH+1 entries built at elaboration. Configuration writes take
// effect at once and should be made while no frame is in flight.
module multi_waveform_tone_generator
    import mwtg_pkg::*;
#(
    parameter int SAMPLE_BITS      = DEF_SAMPLE_BITS,
    parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_wr_en,
    input  wire [CFG_ADDR_W-1:0]   i_cfg_addr,
    input  wire [CFG_DATA_W-1:0]   i_cfg_wr_data,
    input  wire                    s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire [7:0]              s_axis_tdata,  // [0] restart, [7:1] zero
    input  wire                    s_axis_tlast,  // block_last
    output logic                   m_axis_tvalid,
    input  wire                    m_axis_tready,
    output logic [31:0]            m_axis_tdata,  // [15:0] left, [31:16] right
    output logic                   m_axis_tlast   // burst_end
);

    localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PRD_W = 30 + IDX_W;
    localparam longint LIM_FULL = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    localparam logic [15:0] LIMIT = (LIM_FULL > 64'sd32767) ? 16'd32767 : 16'(LIM_FULL);
    localparam logic signed [36:0] Q32_ONE = 37'sh1_0000_0000;

    // quarter-wave sine table
    logic [14:0] w_rom [0:SINE_TABLE_DEPTH];

    for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
        localparam longint unsigned X  = (HALF_PI_Q30 * k) / SINE_TABLE_DEPTH;
        localparam longint unsigned T1 = X;
        localparam longint unsigned T2 = taylor_next(T1, X) / 6;
        localparam longint unsigned T3 = taylor_next(T2, X) / 20;
        localparam longint unsigned T4 = taylor_next(T3, X) / 42;
        localparam longint unsigned T5 = taylor_next(T4, X) / 72;
        localparam longint unsigned T6 = taylor_next(T5, X) / 110;
        localparam longint unsigned T7 = taylor_next(T6, X) / 156;
        localparam longint unsigned T8 = taylor_next(T7, X) / 210;
        localparam longint unsigned T9 = taylor_next(T8, X) / 272;
        localparam longint S = longint'(T1) - longint'(T2) + longint'(T3)
                             - longint'(T4) + longint'(T5) - longint'(T6)
                             + longint'(T7) - longint'(T8) + longint'(T9);
        localparam longint SC = (S < 0) ? 64'sd0 : ((S > ONE_Q30) ? ONE_Q30 : S);
        localparam longint E  = (SC * 32767 + 64'sd536870912) >>> 30;
        localparam longint EC = (E > 32767) ? 64'sd32767 : E;
        assign w_rom[k] = 15'(EC);
    end

    // configuration registers
    logic [2:0]  r_waveform;
    logic [15:0] r_period_whole;
    logic [15:0] r_period_frac;
    logic [31:0] r_phase_step;
    logic [14:0] r_amplitude;
    logic [1:0]  r_chan_en;

    // tone state
    logic [15:0] r_pos,   n_pos;
    logic [31:0] r_ramp,  n_ramp;
    logic [31:0] r_sine,  n_sine;
    logic [15:0] r_lfsr,  n_lfsr;

    // pipeline
    logic        r_s1_v, r_s2_v, r_s3_v;
    logic [32:0] r_s1_mag;
    t_scale      r_s1_scale, r_s2_scale;
    logic        r_s1_neg, r_s2_neg;
    logic [1:0]  r_s1_en, r_s2_en;
    logic        r_s1_last, r_s2_last;
    logic [47:0] r_s2_prod;

    logic adv1, adv2, adv3, s_fire;

    assign adv3 = !r_s3_v || m_axis_tready;
    assign adv2 = !r_s2_v || adv3;
    assign adv1 = !r_s1_v || adv2;
    assign s_axis_tready = adv1;
    assign s_fire = s_axis_tvalid && adv1;

    // frame operand from the current state
    logic [15:0]          w_pos0, w_pos1, w_pos_inc;
    logic [31:0]          w_ramp0, w_ramp1, w_sph;
    logic                 w_first_half;
    logic [PRD_W-1:0]     w_idx_prod;
    logic [IDX_W-1:0]     w_idx_raw, w_idx;
    logic [15:0]          w_lfsr_step;
    logic signed [36:0]   w_f2, w_f4, w_saw, w_tri_raw, w_tri, w_v;
    logic [32:0]          w_mag;
    t_scale               w_scale;
    logic                 w_neg;
    logic                 w_noise;

    always_comb begin
        w_pos0  = s_axis_tdata[0] ? 16'd0 : r_pos;
        w_ramp0 = s_axis_tdata[0] ? 32'd0 : r_ramp;
        w_sph   = s_axis_tdata[0] ? 32'd0 : r_sine;
        if (w_pos0 >= r_period_whole) begin
            w_pos1  = 16'd0;
            w_ramp1 = 32'd0;
        end else begin
            w_pos1  = w_pos0;
            w_ramp1 = w_ramp0;
        end
        w_first_half = {w_pos1, 17'd0} < {1'b0, r_period_whole, r_period_frac};

        w_idx_prod = {{IDX_W{1'b0}}, w_sph[29:0]} * PRD_W'(SINE_TABLE_DEPTH);
        w_idx_raw  = w_idx_prod[PRD_W-1:30];
        w_idx      = w_sph[30] ? (IDX_W'(SINE_TABLE_DEPTH) - w_idx_raw) : w_idx_raw;

        w_lfsr_step = {1'b0, r_lfsr[15:1]} ^ (r_lfsr[0] ? NOISE_TAPS : 16'd0);

        w_f2 = {4'd0, w_ramp1, 1'b0};
        w_f4 = {3'd0, w_ramp1, 2'b0};
        w_saw = w_f2 - Q32_ONE;
        w_tri_raw = w_first_half ? (w_f4 - Q32_ONE) : ((Q32_ONE + Q32_ONE + Q32_ONE) - w_f4);
        if (w_tri_raw > Q32_ONE) begin
            w_tri = Q32_ONE;
        end else if (w_tri_raw < -Q32_ONE) begin
            w_tri = -Q32_ONE;
        end else begin
            w_tri = w_tri_raw;
        end

        w_v     = w_saw;
        w_noise = 1'b0;
        case (r_waveform)
            TONE_SINE: begin
                w_mag   = {18'd0, w_rom[w_idx]};
                w_scale = SCALE_DIV_15;
                w_neg   = w_sph[31];
            end
            TONE_SQUARE: begin
                w_mag   = 33'h1_0000_0000;
                w_scale = SCALE_Q32;
                w_neg   = !w_first_half;
            end
            TONE_SAW, TONE_TRIANGLE: begin
                w_v     = (r_waveform == TONE_TRIANGLE) ? w_tri : w_saw;
                w_neg   = w_v[36];
                w_mag   = w_v[36] ? 33'(-w_v) : w_v[32:0];
                w_scale = SCALE_Q32;
            end
            default: begin
                w_noise = 1'b1;
                w_mag   = {17'd0, w_lfsr_step};
                w_scale = SCALE_DIV_16;
                w_neg   = 1'b0;
            end
        endcase

        n_sine    = w_sph + r_phase_step;
        w_pos_inc = w_pos1 + 16'd1;
        if (w_pos_inc >= r_period_whole) begin
            n_pos  = 16'd0;
            n_ramp = 32'd0;
        end else begin
            n_pos  = w_pos_inc;
            n_ramp = w_ramp1 + r_phase_step;
        end
        n_lfsr = w_noise ? w_lfsr_step : r_lfsr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waveform     <= TONE_SINE;
            r_period_whole <= RST_PERIOD_WHOLE;
            r_period_frac  <= RST_PERIOD_FRAC;
            r_phase_step   <= RST_PHASE_STEP;
            r_amplitude    <= 15'd0;
            r_chan_en      <= 2'd0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                REG_WAVEFORM:       r_waveform     <= i_cfg_wr_data[2:0];
                REG_PERIOD_WHOLE:   r_period_whole <= i_cfg_wr_data[15:0];
                REG_PERIOD_FRAC:    r_period_frac  <= i_cfg_wr_data[15:0];
                REG_PHASE_STEP:     r_phase_step   <= i_cfg_wr_data;
                REG_AMPLITUDE:      r_amplitude    <= i_cfg_wr_data[14:0];
                REG_CHANNEL_ENABLE: r_chan_en      <= i_cfg_wr_data[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= 16'd0;
            r_ramp <= 32'd0;
            r_sine <= 32'd0;
            r_lfsr <= NOISE_SEED;
        end else if (s_fire) begin
            r_pos  <= n_pos;
            r_ramp <= n_ramp;
            r_sine <= n_sine;
            r_lfsr <= n_lfsr;
        end
    end

    // stage 1: operand
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (adv1) begin
            r_s1_v <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_s1_mag   <= w_mag;
            r_s1_scale <= w_scale;
            r_s1_neg   <= w_neg;
            r_s1_en    <= r_chan_en;
            r_s1_last  <= s_axis_tlast;
        end
    end

    // stage 2: amplitude multiply
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (adv2) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2 && r_s1_v) begin
            r_s2_prod  <= {15'd0, r_s1_mag} * {33'd0, r_amplitude};
            r_s2_scale <= r_s1_scale;
            r_s2_neg   <= r_s1_neg;
            r_s2_en    <= r_s1_en;
            r_s2_last  <= r_s1_last;
        end
    end

    // stage 3: scale, clamp, gate
    logic [15:0] w_s15;
    logic [16:0] w_s16;
    logic [15:0] w_q, w_qc, w_val;

    always_comb begin
        w_s15 = {1'b0, r_s2_prod[29:15]} + {1'b0, r_s2_prod[14:0]};
        w_s16 = {2'b0, r_s2_prod[30:16]} + {1'b0, r_s2_prod[15:0]};
        case (r_s2_scale)
            SCALE_Q32: begin
                w_q = r_s2_prod[47:32];
            end
            SCALE_DIV_15: begin
                if (w_s15 >= 16'd65534) begin
                    w_q = {1'b0, r_s2_prod[29:15]} + 16'd2;
                end else if (w_s15 >= 16'd32767) begin
                    w_q = {1'b0, r_s2_prod[29:15]} + 16'd1;
                end else begin
                    w_q = {1'b0, r_s2_prod[29:15]};
                end
            end
            default: begin
                w_q = {1'b0, r_s2_prod[30:16]} + {15'd0, (w_s16 >= 17'd65535)};
            end
        endcase
        w_qc  = (w_q > LIMIT) ? LIMIT : w_q;
        w_val = r_s2_neg ? (16'd0 - w_qc) : w_qc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (adv3) begin
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv3 && r_s2_v) begin
            m_axis_tdata[15:0]  <= r_s2_en[0] ? w_val : 16'd0;
            m_axis_tdata[31:16] <= r_s2_en[1] ? w_val : 16'd0;
            m_axis_tlast        <= r_s2_last;
        end
    end

    assign m_axis_tvalid = r_s3_v;

`ifndef SYNTHESIS
    a_pos_in_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && !i_cfg_wr_en) |=> ((r_pos < r_period_whole) || (r_pos == 16'd0)))
        else $error("period position escaped the period");

    a_lfsr_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lfsr != 16'd0)
        else $error("noise register locked at zero");

    a_left_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (($signed(m_axis_tdata[15:0]) <= $signed(LIMIT))
                        && ($signed(m_axis_tdata[15:0]) >= -$signed(LIMIT))))
        else $error("left sample beyond limit");

    a_right_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (($signed(m_axis_tdata[31:16]) <= $signed(LIMIT))
                        && ($signed(m_axis_tdata[31:16]) >= -$signed(LIMIT))))
        else $error("right sample beyond limit");
`endif

endmodule
`default_nettype wire
